// File: rtl/vliw_bundle_executor_top_macros.svh
// assertion macros for the vliw bundle executor top level
`ifndef VLIW_BUNDLE_EXECUTOR_TOP_MACROS_SVH
`define VLIW_BUNDLE_EXECUTOR_TOP_MACROS_SVH

// implication in the same cycle
`define VBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication in the next cycle
`define VBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/vbe_pkg.sv
// shared constants, opcodes and control types of the vliw bundle executor
package vbe_pkg;

    localparam int REG_DEPTH  = 512;
    localparam int REG_AW     = $clog2(REG_DEPTH);
    localparam int MEM_DEPTH  = 256;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int SLOT_COUNT = 4;
    localparam int SRC_COUNT  = 3;

    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_ADD     = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_AND     = 5'd3;
    localparam logic [4:0] OP_OR      = 5'd4;
    localparam logic [4:0] OP_XOR     = 5'd5;
    localparam logic [4:0] OP_SHL     = 5'd6;
    localparam logic [4:0] OP_SHR     = 5'd7;
    localparam logic [4:0] OP_SLT     = 5'd8;
    localparam logic [4:0] OP_MOV     = 5'd9;
    localparam logic [4:0] OP_LI      = 5'd10;
    localparam logic [4:0] OP_MUL     = 5'd11;
    localparam logic [4:0] OP_MULADD  = 5'd12;
    localparam logic [4:0] OP_LW      = 5'd13;
    localparam logic [4:0] OP_SW      = 5'd14;
    localparam logic [4:0] OP_PRELOAD = 5'd15;
    localparam logic [4:0] OP_MEMREAD = 5'd16;
    localparam logic [4:0] OP_NEWPROG = 5'd17;

    // commands from controller to datapath
    typedef struct packed {
        logic              accept;
        logic              clr_we;
        logic [REG_AW-1:0] clr_addr;
        logic              commit_start;
        logic              inc_cycle;
        logic              rd_issue;
        logic              exa;
        logic              exb;
        logic              wr;
        logic              finish;
        logic              out_load;
        logic [1:0]        slot;
        logic [1:0]        src;
    } vbe_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic any_valid;
    } vbe_sts_t;

endpackage

// File: rtl/vbe_ctrl.sv
// controller state machine of the vliw bundle executor
module vbe_ctrl
    import vbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] opcode,
    input  logic       last_in_bundle,
    output logic       out_valid,
    input  logic       out_stall,
    input  vbe_sts_t   sts,
    output vbe_cmd_t   cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CLEAR  = 9'b000000010,
        ST_COMMIT = 9'b000000100,
        ST_READ   = 9'b000001000,
        ST_DRAIN  = 9'b000010000,
        ST_EXA    = 9'b000100000,
        ST_EXB    = 9'b001000000,
        ST_WRITE  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        slot_reg, slot_next;
    logic [1:0]        src_reg, src_next;
    logic [REG_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              reply_reg, reply_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              can_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign can_load  = !out_valid_reg || !out_stall;

    // next state and counters
    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        src_next     = src_reg;
        clr_cnt_next = clr_cnt_reg;
        reply_next   = reply_reg;
        cmd          = '0;
        cmd.slot     = slot_reg;
        cmd.src      = src_reg;
        cmd.clr_addr = clr_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    priority if (opcode == OP_NEWPROG)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                        reply_next   = 1'b1;
                    end
                    else if (opcode == OP_PRELOAD || opcode == OP_MEMREAD)
                        state_next = ST_DONE;
                    else if (last_in_bundle)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == REG_AW'(REG_DEPTH - 1))
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
            end
            ST_COMMIT:
            begin
                if (sts.any_valid)
                begin
                    cmd.commit_start = 1'b1;
                    slot_next  = '0;
                    src_next   = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.inc_cycle = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (src_reg == 2'(SRC_COUNT - 1))
                begin
                    src_next  = '0;
                    slot_next = slot_reg + 1'b1;
                    if (slot_reg == 2'(SLOT_COUNT - 1))
                        state_next = ST_DRAIN;
                end
                else
                    src_next = src_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                slot_next  = '0;
                state_next = ST_EXA;
            end
            ST_EXA:
            begin
                cmd.exa    = 1'b1;
                state_next = ST_EXB;
            end
            ST_EXB:
            begin
                cmd.exb   = 1'b1;
                slot_next = slot_reg + 1'b1;
                state_next = (slot_reg == 2'(SLOT_COUNT - 1)) ? ST_WRITE : ST_EXA;
            end
            ST_WRITE:
            begin
                cmd.wr    = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == 2'(SLOT_COUNT - 1))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    cmd.out_load = 1'b1;
                    reply_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            slot_reg      <= '0;
            src_reg       <= '0;
            clr_cnt_reg   <= '0;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            src_reg       <= src_next;
            clr_cnt_reg   <= clr_cnt_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/vbe_datapath.sv
// datapath of the vliw bundle executor: slot buffer, register file, memory, alu
module vbe_datapath
    import vbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vbe_cmd_t    cmd,
    output vbe_sts_t    sts,
    input  logic        cfg_write_en,
    input  logic [9:0]  cfg_write_data,
    input  logic [4:0]  opcode,
    input  logic [1:0]  slot_index,
    input  logic [8:0]  dest_reg,
    input  logic [8:0]  src_a,
    input  logic [8:0]  src_b,
    input  logic [8:0]  src_c,
    input  logic [31:0] immediate,
    input  logic [7:0]  mem_address,
    output logic [31:0] cycle_count,
    output logic [31:0] read_data
);

    // storage
    logic [31:0] rf_mem [REG_DEPTH];
    logic [31:0] rt_mem [REG_DEPTH];
    logic [31:0] dm_mem [MEM_DEPTH];

    logic [9:0]  reg_count_reg;
    logic [9:0]  reg_limit;
    logic [31:0] cycle_reg, cycle_next;
    logic [31:0] stall_reg;

    logic        slot_valid_reg [SLOT_COUNT];
    logic [4:0]  slot_op_reg    [SLOT_COUNT];
    logic [8:0]  slot_dst_reg   [SLOT_COUNT];
    logic [8:0]  slot_src_reg   [SLOT_COUNT][SRC_COUNT];
    logic [31:0] slot_imm_reg   [SLOT_COUNT];

    logic [31:0] opnd_reg [SLOT_COUNT][SRC_COUNT];
    logic [31:0] val_reg  [SLOT_COUNT];
    logic [MEM_AW-1:0] addr_reg [SLOT_COUNT];

    logic        cap_en_reg, cap_ok_reg;
    logic [1:0]  cap_slot_reg, cap_src_reg;
    logic [31:0] rf_rdata_reg, rt_rdata_reg, dm_rdata_reg;
    logic        memread_reg;
    logic [31:0] out_cycle_reg, out_rdata_reg;

    logic [8:0]        rd_idx;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata, rt_wdata;
    logic              dm_we, dm_re;
    logic [MEM_AW-1:0] dm_waddr, dm_raddr;
    logic [31:0]       dm_wdata;
    logic [31:0]       ex_a, ex_b, ex_c, ex_imm, ex_val;
    logic [4:0]        ex_op, wr_op;
    logic [MEM_AW-1:0] ex_addr;
    logic              wr_valid;

    function automatic logic reg_ok(input logic [8:0] idx, input logic [9:0] lim);
        return (idx != 9'd0) && ({1'b0, idx} < lim);
    endfunction

    function automatic logic [31:0] alu(input logic [4:0] op, input logic [31:0] a,
                                        input logic [31:0] b, input logic [31:0] c,
                                        input logic [31:0] imm);
        logic [31:0] r;
        unique case (op)
            OP_ADD:    r = a + b;
            OP_SUB:    r = a - b;
            OP_AND:    r = a & b;
            OP_OR:     r = a | b;
            OP_XOR:    r = a ^ b;
            OP_SHL:    r = a << b[4:0];
            OP_SHR:    r = a >> b[4:0];
            OP_SLT:    r = (a < b) ? 32'd1 : 32'd0;
            OP_MOV:    r = a;
            OP_LI:     r = imm;
            OP_MUL:    r = a * b;
            OP_MULADD: r = a * b + c;
            default:   r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] latency(input logic [4:0] op);
        logic [31:0] l;
        if (op == OP_MUL || op == OP_MULADD)
            l = 32'd3;
        else if (op == OP_LW)
            l = 32'd4;
        else
            l = 32'd1;
        return l;
    endfunction

    assign reg_limit = (reg_count_reg > 10'(REG_DEPTH)) ? 10'(REG_DEPTH) : reg_count_reg;
    assign sts.any_valid = slot_valid_reg[0] || slot_valid_reg[1] ||
                           slot_valid_reg[2] || slot_valid_reg[3];

    // register file read address
    assign rd_idx = slot_src_reg[cmd.slot][cmd.src];

    // execute operands of the selected slot
    assign ex_op   = slot_op_reg[cmd.slot];
    assign ex_a    = opnd_reg[cmd.slot][0];
    assign ex_b    = opnd_reg[cmd.slot][1];
    assign ex_c    = opnd_reg[cmd.slot][2];
    assign ex_imm  = slot_imm_reg[cmd.slot];
    assign ex_val  = (ex_op == OP_SW) ? ex_b : alu(ex_op, ex_a, ex_b, ex_c, ex_imm);
    assign ex_addr = MEM_AW'(ex_a + ex_imm);

    // write-back selection
    assign wr_op    = slot_op_reg[cmd.slot];
    assign wr_valid = cmd.wr && slot_valid_reg[cmd.slot];

    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = cmd.clr_addr;
        rf_wdata = '0;
        rt_wdata = '0;
        if (cmd.clr_we)
            rf_we = 1'b1;
        else if (wr_valid && wr_op != OP_SW && reg_ok(slot_dst_reg[cmd.slot], reg_limit))
        begin
            rf_we    = 1'b1;
            rf_waddr = REG_AW'(slot_dst_reg[cmd.slot]);
            rf_wdata = val_reg[cmd.slot];
            rt_wdata = stall_reg + latency(wr_op);
        end
    end

    always_comb
    begin
        dm_we    = 1'b0;
        dm_waddr = cmd.clr_addr[MEM_AW-1:0];
        dm_wdata = '0;
        priority if (cmd.clr_we)
            dm_we = 1'b1;
        else if (cmd.accept && opcode == OP_PRELOAD)
        begin
            dm_we    = 1'b1;
            dm_waddr = MEM_AW'(mem_address);
            dm_wdata = immediate;
        end
        else if (wr_valid && wr_op == OP_SW)
        begin
            dm_we    = 1'b1;
            dm_waddr = addr_reg[cmd.slot];
            dm_wdata = val_reg[cmd.slot];
        end
    end

    assign dm_re    = (cmd.accept && opcode == OP_MEMREAD) || cmd.exa;
    assign dm_raddr = cmd.exa ? ex_addr : MEM_AW'(mem_address);

    // register file and ready times
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
            rt_mem[rf_waddr] <= rt_wdata;
        end
        if (cmd.rd_issue)
        begin
            rf_rdata_reg <= rf_mem[REG_AW'(rd_idx)];
            rt_rdata_reg <= rt_mem[REG_AW'(rd_idx)];
        end
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (dm_we)
            dm_mem[dm_waddr] <= dm_wdata;
        if (dm_re)
            dm_rdata_reg <= dm_mem[dm_raddr];
    end

    // cycle counter
    always_comb
    begin
        cycle_next = cycle_reg;
        priority if (cmd.accept && opcode == OP_NEWPROG)
            cycle_next = '0;
        else if (cmd.inc_cycle)
            cycle_next = cycle_reg + 32'd1;
        else if (cmd.finish)
            cycle_next = stall_reg + 32'd1;
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_count_reg <= '0;
            cycle_reg     <= '0;
            cap_en_reg    <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                reg_count_reg <= cfg_write_data;
            cycle_reg  <= cycle_next;
            cap_en_reg <= cmd.rd_issue;
            if (cmd.wr)
                slot_valid_reg[cmd.slot] <= 1'b0;
            else if (cmd.accept && opcode == OP_NEWPROG)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    slot_valid_reg[i] <= 1'b0;
            end
            else if (cmd.accept && opcode >= OP_ADD && opcode <= OP_SW)
                slot_valid_reg[slot_index] <= 1'b1;
        end
    end

    // slot buffer payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && opcode >= OP_ADD && opcode <= OP_SW)
        begin
            slot_op_reg[slot_index]     <= opcode;
            slot_dst_reg[slot_index]    <= dest_reg;
            slot_src_reg[slot_index][0] <= src_a;
            slot_src_reg[slot_index][1] <= src_b;
            slot_src_reg[slot_index][2] <= src_c;
            slot_imm_reg[slot_index]    <= immediate;
        end
    end

    // operand capture and stall search
    always_ff @(posedge clk)
    begin
        cap_slot_reg <= cmd.slot;
        cap_src_reg  <= cmd.src;
        cap_ok_reg   <= slot_valid_reg[cmd.slot] && reg_ok(rd_idx, reg_limit);
        if (cmd.commit_start)
            stall_reg <= cycle_reg;
        else if (cap_en_reg && cap_ok_reg && rt_rdata_reg > stall_reg)
            stall_reg <= rt_rdata_reg;
        if (cap_en_reg)
            opnd_reg[cap_slot_reg][cap_src_reg] <= cap_ok_reg ? rf_rdata_reg : 32'd0;
    end

    // per-slot execute results
    always_ff @(posedge clk)
    begin
        if (cmd.exa)
        begin
            val_reg[cmd.slot]  <= ex_val;
            addr_reg[cmd.slot] <= ex_addr;
        end
        if (cmd.exb && ex_op == OP_LW)
            val_reg[cmd.slot] <= dm_rdata_reg;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            memread_reg <= (opcode == OP_MEMREAD);
        if (cmd.out_load)
        begin
            out_cycle_reg <= cycle_reg;
            out_rdata_reg <= memread_reg ? dm_rdata_reg : 32'd0;
        end
    end

    assign cycle_count = out_cycle_reg;
    assign read_data   = out_rdata_reg;

endmodule

// File: rtl/vliw_bundle_executor_top.sv
// top level of the vliw bundle executor
// One word is taken at a time. A slot item that does not close a bundle, a
// preload and a memread go from acceptance straight to the load of the result
// word; a bundle with no active slots first checks the slots. Closing a bundle
// with active slots passes through the accept, a check of the slots, twelve
// source reads through the single read port of the register file and
// ready-time memory, a drain state, the execute states EXA and EXB for each slot
// on the shared alu and data memory read port, a write-back per slot and the
// load of the result, which waits while out_stall holds an earlier result.
// After reset and after newprogram a clearing sweep over the 512 register-file
// addresses zeroes the register file, ready times and data memory; no word is
// taken meanwhile, and newprogram's result follows the sweep. The next word is
// taken while a result still waits on out_stall.
module vliw_bundle_executor_top
    import vbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [9:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  opcode,
    input  logic [1:0]  slot_index,
    input  logic [8:0]  dest_reg,
    input  logic [8:0]  src_a,
    input  logic [8:0]  src_b,
    input  logic [8:0]  src_c,
    input  logic [31:0] immediate,
    input  logic [7:0]  mem_address,
    input  logic        last_in_bundle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] cycle_count,
    output logic [31:0] read_data
);

`include "vliw_bundle_executor_top_macros.svh"

    vbe_cmd_t cmd;
    vbe_sts_t sts;

    // controller
    vbe_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .last_in_bundle (last_in_bundle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sts            (sts),
        .cmd            (cmd)
    );

    // datapath
    vbe_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .slot_index     (slot_index),
        .dest_reg       (dest_reg),
        .src_a          (src_a),
        .src_b          (src_b),
        .src_c          (src_c),
        .immediate      (immediate),
        .mem_address    (mem_address),
        .cycle_count    (cycle_count),
        .read_data      (read_data)
    );

    // one word at a time: an accepted word blocks the input for its duration
    `VBE_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall)
    // a new result appears only as the block returns to taking words
    `VBE_ASSERT_NOW(a_result_frees_input, $rose(out_valid), !in_stall)
    // no result is produced in the cycle a word is taken
    `VBE_ASSERT_NEXT(a_no_result_on_accept, in_valid && !in_stall && !out_valid, !out_valid)

endmodule
